@@ sv/pfld_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and sizes for the page framebuffer line-draw block.
// No dependencies; imported by every module that uses frame geometry.
package pfld_pkg;

   localparam int COLUMNS     = 128;
   localparam int ROWS        = 64;
   localparam int FRAME_BYTES = COLUMNS * ROWS / 8;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);

   // Byte index span: start of a line on any 8-bit row, plus 256 bytes of column overshoot
   localparam int IDX_SPAN = 32 * COLUMNS + 256;
   localparam int IDX_W0   = $clog2(IDX_SPAN);
   localparam int IDX_W    = (IDX_W0 > 10) ? IDX_W0 : 10;

   localparam logic [IDX_W-1:0]  FRAME_END = IDX_W'(FRAME_BYTES);
   localparam logic [IDX_W-1:0]  COL_STEP  = IDX_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(FRAME_BYTES - 1);

   localparam logic [7:0]  FULL_MASK    = 8'hff;
   localparam logic [6:0]  PCT_MAX      = 7'd100;
   // n / 100 == (n * 5243) >> 19 for n below 16384
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_PLOT  = 3'd1;
   localparam logic [2:0] OP_HLINE = 3'd2;
   localparam logic [2:0] OP_VLINE = 3'd3;
   localparam logic [2:0] OP_RECT  = 3'd4;
   localparam logic [2:0] OP_BAR   = 3'd5;
   localparam logic [2:0] OP_READ  = 3'd6;

   localparam logic [1:0] JOB_HLINE = 2'd0;
   localparam logic [1:0] JOB_VLINE = 2'd1;
   localparam logic [1:0] JOB_CLEAR = 2'd2;
   localparam logic [1:0] JOB_READ  = 2'd3;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] x;
      logic [5:0] y;
      logic [7:0] length;
      logic [6:0] height;
      logic [7:0] pattern;
      logic [7:0] percent;
      logic [9:0] address;
   } item_type;

   // One primitive for the walker: hline uses count as columns, vline as rows
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] count;
      logic [7:0] pattern;
      logic [9:0] address;
   } job_type;

   typedef struct packed {
      logic       ready;
      logic [7:0] read_data;
   } walk_status_type;

   function automatic logic [7:0] from_bit(input logic [2:0] b);
      return FULL_MASK << b;
   endfunction

endpackage

@@ sv/pfld_ram.sv @@
`timescale 1ns / 1ps
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module pfld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pfld_walker.sv @@
`timescale 1ns / 1ps
// Shared read-modify-write walker over the frame RAM: hline, vline, clear, read.
// Depends on pfld_pkg and pfld_ram.
module pfld_walker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  pfld_pkg::job_type         job,
   output pfld_pkg::walk_status_type status
);
   import pfld_pkg::*;

   localparam logic [2:0] W_IDLE = 3'd0;
   localparam logic [2:0] W_CLR  = 3'd1;
   localparam logic [2:0] W_STEP = 3'd2;
   localparam logic [2:0] W_WAIT = 3'd3;
   localparam logic [2:0] W_RDB  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        remain_ff, remain_in;
   logic [7:0]        pat_ff, pat_in;
   logic [7:0]        rowmask_ff, rowmask_in;
   logic [7:0]        lo_ff, lo_in;
   logic [7:0]        hi_ff, hi_in;
   logic              first_ff, first_in;
   logic              vert_ff, vert_in;
   logic [7:0]        mask_ff, mask_in;
   logic [ADDR_W-1:0] wr_idx_ff, wr_idx_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [7:0]        data_ff, data_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   logic [7:0]        ram_wd, ram_rd;

   logic [IDX_W-1:0]  start_idx, rd_idx;
   logic [7:0]        row_end, vpages, vmask, mask_now;

   pfld_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign start_idx = IDX_W'(IDX_W'(job.row[7:3]) * COL_STEP) + IDX_W'(job.col);
   assign rd_idx    = IDX_W'(job.address);
   assign row_end   = job.row + job.count;
   assign vpages    = {3'b000, row_end[7:3]} - {3'b000, job.row[7:3]} + 8'd1;

   // first page keeps bits from the start row down, last page drops bits from the end row
   assign vmask    = (first_ff ? lo_ff : FULL_MASK) ^ ((remain_ff == 8'd1) ? hi_ff : 8'd0);
   assign mask_now = vert_ff ? vmask : (pat_ff[0] ? rowmask_ff : 8'd0);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      remain_in  = remain_ff;
      pat_in     = pat_ff;
      rowmask_in = rowmask_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      first_in   = first_ff;
      vert_in    = vert_ff;
      mask_in    = mask_ff;
      wr_idx_in  = wr_idx_ff;
      clr_in     = clr_ff;
      data_in    = data_ff;
      ram_we     = 1'b0;
      ram_wa     = wr_idx_ff;
      ram_wd     = ram_rd ^ mask_ff;
      ram_re     = 1'b0;
      ram_ra     = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               unique case (job.kind)
                  JOB_HLINE: begin
                     idx_in     = start_idx;
                     remain_in  = job.count;
                     pat_in     = job.pattern;
                     rowmask_in = 8'd1 << job.row[2:0];
                     vert_in    = 1'b0;
                     state_in   = W_STEP;
                  end
                  JOB_VLINE: begin
                     idx_in    = start_idx;
                     remain_in = vpages;
                     lo_in     = from_bit(job.row[2:0]);
                     hi_in     = from_bit(row_end[2:0]);
                     first_in  = 1'b1;
                     vert_in   = 1'b1;
                     state_in  = W_STEP;
                  end
                  JOB_CLEAR: begin
                     clr_in   = '0;
                     state_in = W_CLR;
                  end
                  JOB_READ: begin
                     if (rd_idx < FRAME_END) begin
                        ram_re   = 1'b1;
                        ram_ra   = rd_idx[ADDR_W-1:0];
                        state_in = W_RDB;
                     end else begin
                        data_in   = 8'd0;
                        remain_in = 8'd0;
                        state_in  = W_STEP;
                     end
                  end
                  default: state_in = W_IDLE;
               endcase
            end
         end
         W_CLR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            ram_wd = 8'd0;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = W_IDLE;
            end
         end
         W_STEP: begin
            if (remain_ff == 8'd0 || idx_ff >= FRAME_END) begin
               state_in = W_IDLE;
            end else begin
               idx_in    = idx_ff + (vert_ff ? COL_STEP : IDX_W'(1));
               remain_in = remain_ff - 8'd1;
               pat_in    = {pat_ff[0], pat_ff[7:1]};
               first_in  = 1'b0;
               // blank stipple columns and empty masks skip the RAM access and the write-back state
               if (mask_now != 8'd0) begin
                  ram_re    = 1'b1;
                  ram_ra    = idx_ff[ADDR_W-1:0];
                  mask_in   = mask_now;
                  wr_idx_in = idx_ff[ADDR_W-1:0];
                  state_in  = W_WAIT;
               end
            end
         end
         W_WAIT: begin
            ram_we   = 1'b1;
            state_in = W_STEP;
         end
         W_RDB: begin
            data_in  = ram_rd;
            state_in = W_IDLE;
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_CLR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      idx_ff     <= idx_in;
      remain_ff  <= remain_in;
      pat_ff     <= pat_in;
      rowmask_ff <= rowmask_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      first_ff   <= first_in;
      vert_ff    <= vert_in;
      mask_ff    <= mask_in;
      wr_idx_ff  <= wr_idx_in;
      data_ff    <= data_in;
   end

   assign status.ready     = (state_ff == W_IDLE);
   assign status.read_data = data_ff;

`ifndef SYNTHESIS
   a_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == W_WAIT |-> $past(state_ff) == W_STEP)
      else $error("walker write-back without a preceding read");
   a_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == W_WAIT |-> $past(idx_ff) < FRAME_END)
      else $error("walker write-back outside the frame");
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> state_ff == W_CLR && clr_ff == '0)
      else $error("clearing sweep did not start after reset");
`endif

endmodule

@@ sv/pfld_seq.sv @@
`timescale 1ns / 1ps
// Operation sequencer: splits each command into walker primitives, sizes the bar fill.
// Depends on pfld_pkg; drives pfld_walker.
module pfld_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  pfld_pkg::item_type        item,
   input  logic                      out_free,
   output logic                      out_valid,
   output logic [7:0]                out_data,
   input  pfld_pkg::walk_status_type status,
   output logic                      start,
   output pfld_pkg::job_type         job
);
   import pfld_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SINGLE = 4'd1;
   localparam logic [3:0] S_VL1    = 4'd2;
   localparam logic [3:0] S_VL2    = 4'd3;
   localparam logic [3:0] S_HLB    = 4'd4;
   localparam logic [3:0] S_HLT    = 4'd5;
   localparam logic [3:0] S_MUL1   = 4'd6;
   localparam logic [3:0] S_MUL2   = 4'd7;
   localparam logic [3:0] S_FILL   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic        issued_ff, issued_in;
   item_type    item_ff, item_in;
   logic [13:0] prod_ff, prod_in;
   logic [6:0]  solid_ff, solid_in;
   logic [7:0]  row_ff, row_in;

   logic        job_done, wide, fill_more;
   logic [7:0]  yw, yh, left_x, abs_len;
   logic [6:0]  wm2, pct_sat;
   logic [26:0] scaled;

   assign yw        = {2'b00, item_ff.y};
   assign yh        = yw + {1'b0, item_ff.height};
   assign wide      = !item_ff.length[7] && (item_ff.length[6:1] != 6'd0);
   assign wm2       = item_ff.length[6:0] - 7'd2;
   assign pct_sat   = (item_ff.percent > {1'b0, PCT_MAX}) ? PCT_MAX : item_ff.percent[6:0];
   assign left_x    = item_ff.x + item_ff.length;
   assign abs_len   = item_ff.length[7] ? (~item_ff.length + 8'd1) : item_ff.length;
   assign scaled    = 27'(prod_ff) * 27'(DIV100_MUL);
   assign fill_more = (solid_ff != 7'd0) && ((row_ff + 8'd1) < yh);
   assign job_done  = issued_ff && status.ready;
   assign in_ready  = (state_ff == S_IDLE) && status.ready;

   always_comb begin
      job.kind    = JOB_HLINE;
      job.col     = item_ff.x + 8'd1;
      job.row     = yw;
      job.count   = {1'b0, wm2};
      job.pattern = FULL_MASK;
      job.address = item_ff.address;
      unique case (state_ff)
         S_SINGLE: begin
            unique case (item_ff.operation)
               OP_CLEAR: job.kind = JOB_CLEAR;
               OP_READ:  job.kind = JOB_READ;
               OP_HLINE: begin
                  job.col     = item_ff.length[7] ? left_x : item_ff.x;
                  job.count   = abs_len;
                  job.pattern = item_ff.pattern;
               end
               default: begin
                  job.col   = item_ff.x;
                  job.count = 8'd1;
               end
            endcase
         end
         S_VL1: begin
            job.kind  = JOB_VLINE;
            job.col   = item_ff.x;
            job.count = {1'b0, item_ff.height};
         end
         S_VL2: begin
            job.kind  = JOB_VLINE;
            job.col   = left_x - 8'd1;
            job.count = {1'b0, item_ff.height};
         end
         S_HLB:  job.row = yh - 8'd1;
         S_FILL: begin
            job.row   = row_ff;
            job.count = {1'b0, solid_ff};
         end
         default: job.kind = JOB_HLINE;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      item_in   = item_ff;
      prod_in   = prod_ff;
      solid_in  = solid_ff;
      row_in    = row_ff;
      start     = 1'b0;
      out_valid = 1'b0;
      out_data  = 8'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid && status.ready) begin
               item_in   = item;
               issued_in = 1'b0;
               unique case (item.operation)
                  OP_CLEAR, OP_PLOT, OP_HLINE, OP_READ: state_in = S_SINGLE;
                  OP_VLINE, OP_RECT, OP_BAR:            state_in = S_VL1;
                  default:                              state_in = S_DONE;
               endcase
            end
         end
         S_SINGLE, S_VL1, S_VL2, S_HLB, S_HLT: begin
            if (!issued_ff && status.ready) begin
               start     = 1'b1;
               issued_in = 1'b1;
            end
            if (job_done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  S_VL1: state_in = (item_ff.operation == OP_VLINE || !wide) ? S_DONE : S_VL2;
                  S_VL2: state_in = S_HLB;
                  S_HLB: state_in = S_HLT;
                  S_HLT: state_in = (item_ff.operation == OP_BAR) ? S_MUL1 : S_DONE;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL1: begin
            prod_in  = 14'(wm2) * 14'(pct_sat);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            solid_in = scaled[DIV100_SHIFT +: 7];
            row_in   = yw + 8'd1;
            state_in = S_FILL;
         end
         S_FILL: begin
            if (!issued_ff) begin
               if (!fill_more) begin
                  state_in = S_DONE;
               end else if (status.ready) begin
                  start     = 1'b1;
                  issued_in = 1'b1;
               end
            end else if (job_done) begin
               issued_in = 1'b0;
               row_in    = row_ff + 8'd1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid = 1'b1;
               out_data  = (item_ff.operation == OP_READ) ? status.read_data : 8'd0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
      item_ff  <= item_in;
      prod_ff  <= prod_in;
      solid_ff <= solid_in;
      row_ff   <= row_in;
   end

`ifndef SYNTHESIS
   a_draw_answers_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && item_ff.operation != OP_READ |-> out_data == 8'd0)
      else $error("drawing command answered with nonzero data");
`endif

endmodule

@@ sv/page_framebuffer_line_draw.sv @@
`timescale 1ns / 1ps
// Top level of the page framebuffer line-draw block: stream ports and result register.
// Depends on pfld_pkg, pfld_seq and pfld_walker.
//
//   channel   ports                          beat carries
//   command   req_tvalid/tready/tdata/tuser  one drawing or read command
//   result    rsp_tvalid/tready/tdata        one byte per command
//
// After reset the frame is zeroed by a sweep over all FRAME_BYTES (1024) bytes; req_tready is low.
// Each written frame byte is read and then written back over the RAM read and write ports;
// a blank stipple column skips the RAM access. A bar adds one hline per fill row.
// One command at a time. A finished result waits in an output register while the next
// command is accepted.
module page_framebuffer_line_draw (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // x[7:0], y[13:8], length[21:14], height[28:22], pattern[36:29],
   // percent[44:37], address[54:45], zero [55]
   input  logic [55:0] req_tdata,
   // operation[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0]
   output logic [7:0]  rsp_tdata
);
   import pfld_pkg::*;

   item_type        item;
   job_type         job;
   walk_status_type wstat;
   logic            start, seq_ready, out_free, out_valid;
   logic [7:0]      out_data;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_data_ff, rsp_data_in;

   assign item.operation = req_tuser[2:0];
   assign item.x         = req_tdata[7:0];
   assign item.y         = req_tdata[13:8];
   assign item.length    = req_tdata[21:14];
   assign item.height    = req_tdata[28:22];
   assign item.pattern   = req_tdata[36:29];
   assign item.percent   = req_tdata[44:37];
   assign item.address   = req_tdata[54:45];

   assign out_free = !rsp_valid_ff || rsp_tready;

   pfld_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (seq_ready),
      .item      (item),
      .out_free  (out_free),
      .out_valid (out_valid),
      .out_data  (out_data),
      .status    (wstat),
      .start     (start),
      .job       (job)
   );

   pfld_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .job    (job),
      .status (wstat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = seq_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command taken while the previous one is still running");
`endif

endmodule
